### hw/rtl/osp_pkg.sv
package osp_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned NUM_TERMS  = 4;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned DMAG_W     = COORD_W;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned SQ_W       = 2 * DIFF_W;
  localparam int unsigned SUMSQ_W    = 68;
  localparam int unsigned ROOT_W     = 64;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned EXT_BITS   = 30;
  localparam int unsigned DVD_W      = 96;
  localparam int unsigned QUOT_W     = 41;
  localparam int unsigned DIV_STEPS  = QUOT_W;
  localparam int unsigned SUM_W      = QUOT_W + 2;

  // pipeline depth: four front stages, root, divide with its prep stage, output register
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned DIV_STAGES   = DIV_STEPS + 1;
  localparam int unsigned LATENCY      = FRONT_STAGES + SQRT_STEPS + DIV_STAGES + 1;

  localparam logic [DIR_W-1:0]  DIR_LINE = 2'b00;
  localparam logic [QUOT_W-1:0] TERM_CAP = {1'b1, {(QUOT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] height;
    logic [DIR_W-1:0]          direction;
    logic                      is_line;
    logic                      degen;
  } item_t;

  typedef struct packed {
    item_t                             item;
    logic [NUM_TERMS-1:0][PROD_W-1:0]  num;
    logic [NUM_TERMS-1:0]              neg;
  } sq_sb_t;

  typedef struct packed {
    item_t                item;
    logic [NUM_TERMS-1:0] neg;
  } dv_sb_t;

endpackage

### hw/rtl/osp_sqrt_pipe.sv
module osp_sqrt_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [osp_pkg::SUMSQ_W-1:0]   rad_i,
  input  osp_pkg::sq_sb_t               sb_i,
  output logic                          valid_o,
  output logic [osp_pkg::ROOT_W-1:0]    root_o,
  output osp_pkg::sq_sb_t               sb_o
);
  import osp_pkg::*;

  // one root bit per stage, radicand is rad_i followed by 60 zero bits
  logic                 valid_q [SQRT_STEPS];
  logic [SUMSQ_W-1:0]   rem_q   [SQRT_STEPS];
  logic [SUMSQ_W-1:0]   rad_q   [SQRT_STEPS];
  logic [ROOT_W-1:0]    root_q  [SQRT_STEPS];
  sq_sb_t               sb_q    [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic               v_p;
    logic [SUMSQ_W-1:0] rem_p;
    logic [SUMSQ_W-1:0] rad_p;
    logic [ROOT_W-1:0]  root_p;
    sq_sb_t             sb_p;
    logic [SUMSQ_W-1:0] rem_sh;
    logic [SUMSQ_W-1:0] trial;
    logic [SUMSQ_W-1:0] rem_n;
    logic               ge;

    if (k == 0) begin : g_head
      assign v_p    = valid_i;
      assign rem_p  = '0;
      assign rad_p  = rad_i;
      assign root_p = '0;
      assign sb_p   = sb_i;
    end else begin : g_body
      assign v_p    = valid_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign root_p = root_q[k-1];
      assign sb_p   = sb_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_p[SUMSQ_W-3:0], rad_p[SUMSQ_W-1 -: 2]};
      trial  = {{(SUMSQ_W-ROOT_W-2){1'b0}}, root_p, 2'b01};
      ge     = (rem_sh >= trial);
      rem_n  = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_n;
      rad_q[k]  <= {rad_p[SUMSQ_W-3:0], 2'b00};
      root_q[k] <= {root_p[ROOT_W-2:0], ge};
      sb_q[k]   <= sb_p;
    end
  end

  assign valid_o = valid_q[SQRT_STEPS-1];
  assign root_o  = root_q[SQRT_STEPS-1];
  assign sb_o    = sb_q[SQRT_STEPS-1];

endmodule

### hw/rtl/osp_div_pipe.sv
module osp_div_pipe (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 valid_i,
  input  logic [osp_pkg::ROOT_W-1:0]                           len_i,
  input  logic [osp_pkg::NUM_TERMS-1:0][osp_pkg::PROD_W-1:0]   num_i,
  input  osp_pkg::dv_sb_t                                      sb_i,
  output logic                                                 valid_o,
  output logic [osp_pkg::NUM_TERMS-1:0][osp_pkg::QUOT_W-1:0]   quot_o,
  output osp_pkg::dv_sb_t                                      sb_o
);
  import osp_pkg::*;

  // rounded quotient of num * 2^30 by len, capped at 2^40, one bit per stage
  logic [NUM_TERMS-1:0][DVD_W-1:0] dvd;
  logic [NUM_TERMS-1:0]            ovf;

  always_comb begin
    for (int i = 0; i < NUM_TERMS; i++) begin
      dvd[i] = {2'b00, num_i[i], {EXT_BITS{1'b0}}}
             + {{(DVD_W-ROOT_W+1){1'b0}}, len_i[ROOT_W-1:1]};
      ovf[i] = ({{(ROOT_W+QUOT_W-DVD_W){1'b0}}, dvd[i]} >= {len_i, {QUOT_W{1'b0}}});
    end
  end

  logic                                 pv_q;
  logic [ROOT_W-1:0]                    plen_q;
  logic [NUM_TERMS-1:0][ROOT_W-1:0]     prem_q;
  logic [NUM_TERMS-1:0][QUOT_W-1:0]     plo_q;
  logic [NUM_TERMS-1:0]                 povf_q;
  dv_sb_t                               psb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    plen_q <= len_i;
    povf_q <= ovf;
    psb_q  <= sb_i;
    for (int i = 0; i < NUM_TERMS; i++) begin
      prem_q[i] <= {{(ROOT_W-DVD_W+QUOT_W){1'b0}}, dvd[i][DVD_W-1:QUOT_W]};
      plo_q[i]  <= dvd[i][QUOT_W-1:0];
    end
  end

  logic                             valid_q [DIV_STEPS];
  logic [ROOT_W-1:0]                len_q   [DIV_STEPS];
  logic [NUM_TERMS-1:0][ROOT_W-1:0] rem_q   [DIV_STEPS];
  logic [NUM_TERMS-1:0][QUOT_W-1:0] lo_q    [DIV_STEPS];
  logic [NUM_TERMS-1:0][QUOT_W-1:0] q_q     [DIV_STEPS];
  logic [NUM_TERMS-1:0]             ovf_q   [DIV_STEPS];
  dv_sb_t                           sb_q    [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic                             v_p;
    logic [ROOT_W-1:0]                len_p;
    logic [NUM_TERMS-1:0][ROOT_W-1:0] rem_p;
    logic [NUM_TERMS-1:0][QUOT_W-1:0] lo_p;
    logic [NUM_TERMS-1:0][QUOT_W-1:0] q_p;
    logic [NUM_TERMS-1:0]             ovf_p;
    dv_sb_t                           sb_p;
    logic [NUM_TERMS-1:0][ROOT_W:0]   rem_sh;
    logic [NUM_TERMS-1:0][ROOT_W:0]   rem_n;
    logic [NUM_TERMS-1:0]             ge;

    if (k == 0) begin : g_head
      assign v_p   = pv_q;
      assign len_p = plen_q;
      assign rem_p = prem_q;
      assign lo_p  = plo_q;
      assign q_p   = '0;
      assign ovf_p = povf_q;
      assign sb_p  = psb_q;
    end else begin : g_body
      assign v_p   = valid_q[k-1];
      assign len_p = len_q[k-1];
      assign rem_p = rem_q[k-1];
      assign lo_p  = lo_q[k-1];
      assign q_p   = q_q[k-1];
      assign ovf_p = ovf_q[k-1];
      assign sb_p  = sb_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < NUM_TERMS; i++) begin
        rem_sh[i] = {rem_p[i], lo_p[i][QUOT_W-1]};
        ge[i]     = (rem_sh[i] >= {1'b0, len_p});
        rem_n[i]  = ge[i] ? (rem_sh[i] - {1'b0, len_p}) : rem_sh[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      len_q[k] <= len_p;
      ovf_q[k] <= ovf_p;
      sb_q[k]  <= sb_p;
      for (int i = 0; i < NUM_TERMS; i++) begin
        rem_q[k][i] <= rem_n[i][ROOT_W-1:0];
        lo_q[k][i]  <= {lo_p[i][QUOT_W-2:0], 1'b0};
        q_q[k][i]   <= {q_p[i][QUOT_W-2:0], ge[i]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_TERMS; i++) begin
      if (ovf_q[DIV_STEPS-1][i] || q_q[DIV_STEPS-1][i][QUOT_W-1]) begin
        quot_o[i] = TERM_CAP;
      end else begin
        quot_o[i] = q_q[DIV_STEPS-1][i];
      end
    end
  end

  assign valid_o = valid_q[DIV_STEPS-1];
  assign sb_o    = sb_q[DIV_STEPS-1];

endmodule

### hw/rtl/offset_path_segment.sv
// channel    direction  handshake                  payload
// segment    in         start, busy                start_x_i .. direction_i
// result     out        valid_o strobe, one cycle  out_start_x_o .. saturated_o
// offset     in         cfg_we_i                   cfg_wdata_i
//
// fully pipelined: one word may enter every cycle, busy is always low
// each result passes through the whole pipeline: four front stages,
// 64 root stages (one bit each), 42 divide stages (prep plus one bit each),
// and the output register
// asynchronous active-low reset clears the valid bits and the offset register
// the receiver cannot stall, so nothing in the pipeline ever holds
module offset_path_segment (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [osp_pkg::COORD_W-1:0]   start_x_i,
  input  logic signed [osp_pkg::COORD_W-1:0]   start_y_i,
  input  logic signed [osp_pkg::COORD_W-1:0]   end_x_i,
  input  logic signed [osp_pkg::COORD_W-1:0]   end_y_i,
  input  logic signed [osp_pkg::COORD_W-1:0]   center_x_i,
  input  logic signed [osp_pkg::COORD_W-1:0]   center_y_i,
  input  logic signed [osp_pkg::COORD_W-1:0]   height_i,
  input  logic signed [osp_pkg::DIR_W-1:0]     direction_i,
  input  logic                                 cfg_we_i,
  input  logic signed [osp_pkg::COORD_W-1:0]   cfg_wdata_i,
  output logic                                 valid_o,
  output logic signed [osp_pkg::COORD_W-1:0]   out_start_x_o,
  output logic signed [osp_pkg::COORD_W-1:0]   out_start_y_o,
  output logic signed [osp_pkg::COORD_W-1:0]   out_end_x_o,
  output logic signed [osp_pkg::COORD_W-1:0]   out_end_y_o,
  output logic signed [osp_pkg::COORD_W-1:0]   out_center_x_o,
  output logic signed [osp_pkg::COORD_W-1:0]   out_center_y_o,
  output logic signed [osp_pkg::COORD_W-1:0]   out_height_o,
  output logic signed [osp_pkg::DIR_W-1:0]     out_direction_o,
  output logic                                 degenerate_o,
  output logic                                 saturated_o
);
  import osp_pkg::*;

  assign busy = 1'b0;

  // offset register
  logic signed [COORD_W-1:0] dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
    end else if (cfg_we_i) begin
      dist_q <= cfg_wdata_i;
    end
  end

  // stage 1: difference vectors and the signed distance
  // a line uses its travel vector, an arc uses both endpoints relative to the center
  logic                                     is_line;
  logic signed [DIFF_W-1:0]                 dist_ext;
  logic [NUM_TERMS-1:0][DIFF_W-1:0]         diff;
  logic [DIFF_W-1:0]                        bval;
  item_t                                    item_in;

  always_comb begin
    is_line  = (direction_i == DIR_LINE);
    dist_ext = {dist_q[COORD_W-1], dist_q};
    // negative direction flips the offset; the pattern 10 counts as negative
    bval     = (!is_line && direction_i[DIR_W-1]) ? -dist_ext : dist_ext;
    if (is_line) begin
      diff[0] = {end_x_i[COORD_W-1], end_x_i} - {start_x_i[COORD_W-1], start_x_i};
      diff[1] = {end_y_i[COORD_W-1], end_y_i} - {start_y_i[COORD_W-1], start_y_i};
      diff[2] = '0;
      diff[3] = '0;
    end else begin
      diff[0] = {start_x_i[COORD_W-1], start_x_i} - {center_x_i[COORD_W-1], center_x_i};
      diff[1] = {start_y_i[COORD_W-1], start_y_i} - {center_y_i[COORD_W-1], center_y_i};
      diff[2] = {end_x_i[COORD_W-1], end_x_i} - {center_x_i[COORD_W-1], center_x_i};
      diff[3] = {end_y_i[COORD_W-1], end_y_i} - {center_y_i[COORD_W-1], center_y_i};
    end
    item_in.start_x   = start_x_i;
    item_in.start_y   = start_y_i;
    item_in.end_x     = end_x_i;
    item_in.end_y     = end_y_i;
    item_in.center_x  = center_x_i;
    item_in.center_y  = center_y_i;
    item_in.height    = height_i;
    item_in.direction = direction_i;
    item_in.is_line   = is_line;
    item_in.degen     = 1'b0;
  end

  logic                             s1_v_q;
  item_t                            s1_item_q;
  logic [NUM_TERMS-1:0][DIFF_W-1:0] s1_diff_q;
  logic [DIFF_W-1:0]                s1_b_q;

  // stage 2: magnitudes and term signs
  logic                             s2_v_q;
  item_t                            s2_item_q;
  logic [NUM_TERMS-1:0][DIFF_W-1:0] s2_mag_q;
  logic [DMAG_W-1:0]                s2_bmag_q;
  logic [NUM_TERMS-1:0]             s2_neg_q;

  // stage 3: squares and offset numerators
  logic                             s3_v_q;
  item_t                            s3_item_q;
  logic [SQ_W-1:0]                  s3_sq0_q;
  logic [SQ_W-1:0]                  s3_sq1_q;
  logic [NUM_TERMS-1:0][PROD_W-1:0] s3_num_q;
  logic [NUM_TERMS-1:0]             s3_neg_q;

  // stage 4: squared length
  logic                             s4_v_q;
  logic [SUMSQ_W-1:0]               s4_sum_q;
  sq_sb_t                           s4_sb_q;

  logic [NUM_TERMS-1:0][DIFF_W-1:0] mag;
  logic [DIFF_W-1:0]                bmag;
  logic [NUM_TERMS-1:0]             neg;
  logic [NUM_TERMS-1:0][DIFF_W+DMAG_W-1:0] prod;
  item_t                            s2_item_d;

  always_comb begin
    bmag = s1_b_q[DIFF_W-1] ? -s1_b_q : s1_b_q;
    for (int i = 0; i < NUM_TERMS; i++) begin
      mag[i] = s1_diff_q[i][DIFF_W-1] ? -s1_diff_q[i] : s1_diff_q[i];
      neg[i] = s1_diff_q[i][DIFF_W-1] ^ s1_b_q[DIFF_W-1];
    end
    // zero travel vector or start on the center
    s2_item_d       = s1_item_q;
    s2_item_d.degen = (s1_diff_q[0] == '0) && (s1_diff_q[1] == '0);
    for (int i = 0; i < NUM_TERMS; i++) begin
      prod[i] = s2_mag_q[i] * s2_bmag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= start && !busy;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= item_in;
    s1_diff_q <= diff;
    s1_b_q    <= bval;

    s2_item_q       <= s2_item_d;
    s2_mag_q        <= mag;
    s2_bmag_q       <= bmag[DMAG_W-1:0];
    s2_neg_q        <= neg;

    s3_item_q <= s2_item_q;
    s3_sq0_q  <= s2_mag_q[0] * s2_mag_q[0];
    s3_sq1_q  <= s2_mag_q[1] * s2_mag_q[1];
    for (int i = 0; i < NUM_TERMS; i++) begin
      // magnitude below 2^33 times at most 2^31 stays below 2^64
      s3_num_q[i] <= prod[i][PROD_W-1:0];
    end
    s3_neg_q <= s2_neg_q;

    s4_sum_q <= {{(SUMSQ_W-SQ_W){1'b0}}, s3_sq0_q} + {{(SUMSQ_W-SQ_W){1'b0}}, s3_sq1_q};
    s4_sb_q  <= '{item: s3_item_q, num: s3_num_q, neg: s3_neg_q};
  end

  // length or radius, scaled by 2^30
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  sq_sb_t            sq_sb;
  dv_sb_t            dv_sb_in;

  osp_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_v_q),
    .rad_i   (s4_sum_q),
    .sb_i    (s4_sb_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  assign dv_sb_in.item = sq_sb.item;
  assign dv_sb_in.neg  = sq_sb.neg;

  // offset term magnitudes
  logic                             dv_v;
  logic [NUM_TERMS-1:0][QUOT_W-1:0] dv_quot;
  dv_sb_t                           dv_sb;

  osp_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .len_i   (sq_root),
    .num_i   (sq_sb.num),
    .sb_i    (dv_sb_in),
    .valid_o (dv_v),
    .quot_o  (dv_quot),
    .sb_o    (dv_sb)
  );

  // final stage: apply each term with its sign and saturate
  // a line moves x by minus the y term and y by the x term; an arc adds its own term
  logic [NUM_TERMS-1:0][COORD_W-1:0] base;
  logic [NUM_TERMS-1:0][COORD_W-1:0] res;
  logic [NUM_TERMS-1:0]              clip;
  logic [NUM_TERMS-1:0][QUOT_W-1:0]  term;
  logic [NUM_TERMS-1:0]              sub;
  logic signed [SUM_W-1:0]           sum [NUM_TERMS];
  logic signed [SUM_W-1:0]           base_ext [NUM_TERMS];
  logic signed [SUM_W-1:0]           term_ext [NUM_TERMS];

  localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  always_comb begin
    base[0] = dv_sb.item.start_x;
    base[1] = dv_sb.item.start_y;
    base[2] = dv_sb.item.end_x;
    base[3] = dv_sb.item.end_y;
    if (dv_sb.item.is_line) begin
      term[0] = dv_quot[1];  sub[0] = !dv_sb.neg[1];
      term[1] = dv_quot[0];  sub[1] = dv_sb.neg[0];
      term[2] = dv_quot[1];  sub[2] = !dv_sb.neg[1];
      term[3] = dv_quot[0];  sub[3] = dv_sb.neg[0];
    end else begin
      for (int i = 0; i < NUM_TERMS; i++) begin
        term[i] = dv_quot[i];
        sub[i]  = dv_sb.neg[i];
      end
    end
    for (int i = 0; i < NUM_TERMS; i++) begin
      base_ext[i] = {{(SUM_W-COORD_W){base[i][COORD_W-1]}}, base[i]};
      term_ext[i] = {{(SUM_W-QUOT_W){1'b0}}, term[i]};
      sum[i]      = sub[i] ? (base_ext[i] - term_ext[i]) : (base_ext[i] + term_ext[i]);
      // degenerate segments pass the points through
      if (dv_sb.item.degen) begin
        res[i]  = base[i];
        clip[i] = 1'b0;
      end else if (sum[i] > SAT_MAX) begin
        res[i]  = SAT_MAX[COORD_W-1:0];
        clip[i] = 1'b1;
      end else if (sum[i] < SAT_MIN) begin
        res[i]  = SAT_MIN[COORD_W-1:0];
        clip[i] = 1'b1;
      end else begin
        res[i]  = sum[i][COORD_W-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  logic out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    out_start_x_o   <= res[0];
    out_start_y_o   <= res[1];
    out_end_x_o     <= res[2];
    out_end_y_o     <= res[3];
    // lines report a zero center
    out_center_x_o  <= dv_sb.item.is_line ? '0 : dv_sb.item.center_x;
    out_center_y_o  <= dv_sb.item.is_line ? '0 : dv_sb.item.center_y;
    out_height_o    <= dv_sb.item.height;
    out_direction_o <= dv_sb.item.direction;
    degenerate_o    <= dv_sb.item.degen;
    saturated_o     <= |clip;
  end

  assign valid_o = out_v_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without a word accepted at the pipeline depth");

  a_div_follows_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v |-> $past(sq_v, DIV_STAGES))
    else $error("divide output without matching root output");

  a_degen_no_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> !saturated_o)
    else $error("degenerate segment reported as clamped");

  a_line_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (out_direction_o == DIR_LINE) |->
      (out_center_x_o == '0) && (out_center_y_o == '0))
    else $error("line result with nonzero center");
`endif

endmodule
